FILE: src/tlca_pkg.sv
package tlca_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 2048;
    localparam int LEVELS_DEF    = 10;
    localparam int NODE_W        = 10;
    localparam logic [NODE_W-1:0] ROOT_RESET = 10'd1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CLR_ALL,
        CMD_CLR_REACH,
        CMD_ARC_RD,
        CMD_ARC_WR,
        CMD_BINIT,
        CMD_ZLEV,
        CMD_ROOT,
        CMD_QRD,
        CMD_TLOAD,
        CMD_LINK,
        CMD_ERD,
        CMD_JCHK,
        CMD_JSET,
        CMD_PRD,
        CMD_PWR,
        CMD_QRD1,
        CMD_QRD2,
        CMD_QLAT,
        CMD_LRD,
        CMD_LDRD,
        CMD_LCHK,
        CMD_JRD,
        CMD_JCMP,
        CMD_RRD,
        CMD_EMIT_FAIL,
        CMD_EMIT_MET,
        CMD_EMIT_ANC
    } cmd_t;

    typedef enum logic [5:0] {
        ST_CLRALL,
        ST_IDLE,
        ST_ADD,
        ST_ARC_RD,
        ST_ARC_WR,
        ST_ARC_RD2,
        ST_ARC_WR2,
        ST_BCLR,
        ST_BINIT,
        ST_ZLEV0,
        ST_ROOT,
        ST_ZLEVR,
        ST_QPOP,
        ST_TLOAD,
        ST_LINK,
        ST_EDGE,
        ST_JCHK,
        ST_JTEST,
        ST_PRD,
        ST_PWR,
        ST_QCHK0,
        ST_QRD1,
        ST_QRD2,
        ST_QLAT,
        ST_QOK,
        ST_LRD,
        ST_LDRD,
        ST_LCHK,
        ST_MET,
        ST_JRD,
        ST_JCMP,
        ST_RRD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr_last;
        logic edge_ok;
        logic k_last;
        logic k_zero;
        logic root_ok;
        logic q_empty;
        logic link_zero;
        logic j_ok;
        logic q_range_ok;
        logic pair_ok;
        logic met;
        logic out_busy;
    } status_t;

endpackage

FILE: src/tlca_datapath.sv
module tlca_datapath #(
    parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = tlca_pkg::MAX_EDGES_DEF,
    parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlca_pkg::cmd_t                cmd,
    output tlca_pkg::status_t             status,
    input  logic [tlca_pkg::NODE_W-1:0]   in_node_a,
    input  logic [tlca_pkg::NODE_W-1:0]   in_node_b,
    input  logic                          cfg_we,
    input  logic [tlca_pkg::NODE_W-1:0]   cfg_wdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [tlca_pkg::NODE_W-1:0]   out_ancestor,
    output logic                          out_found
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int LW = $clog2(LEVELS);
    localparam int DW = NW + 1;
    localparam int AW = NW + LW;
    localparam int VW = tlca_pkg::NODE_W;

    // storage
    logic [EW:0]   head_mem  [0:MAX_NODES-1];
    logic [VW-1:0] tgt_mem   [0:MAX_EDGES-1];
    logic [EW:0]   nxt_mem   [0:MAX_EDGES-1];
    logic [DW-1:0] depth_mem [0:MAX_NODES-1];
    logic          reach_mem [0:MAX_NODES-1];
    logic [VW-1:0] queue_mem [0:MAX_NODES-1];
    logic [VW-1:0] anc_mem   [0:(MAX_NODES << LW)-1];

    logic [EW:0]   head_q, nxt_q;
    logic [VW-1:0] tgt_q, queue_q, anc_qa, anc_qb;
    logic [DW-1:0] depth_q;
    logic          reach_q;

    // control registers
    logic [NW-1:0] cnt_reg, head_ptr_reg, tail_reg;
    logic [EW:0]   edge_cnt_reg;
    logic [LW-1:0] k_reg;
    logic          out_valid_reg;
    logic [VW-1:0] root_reg;

    // payload registers
    logic [VW-1:0] a_reg, b_reg, t_reg, j_reg, p_reg, x_reg, out_anc_reg;
    logic [EW:0]   link_reg;
    logic [DW-1:0] dt_reg, da_reg, db_reg;
    logic          ra_reg, ok_reg, out_found_reg;

    logic [EW:0]   link_m1;
    logic [LW-1:0] k_m1;
    logic          clr_cmd;

    logic          head_we;
    logic [NW-1:0] head_wa, head_ra;
    logic [EW:0]   head_wd;
    logic          depth_we;
    logic [NW-1:0] depth_wa, depth_ra;
    logic [DW-1:0] depth_wd;
    logic          reach_we, reach_wd;
    logic [NW-1:0] reach_wa, reach_ra;
    logic          queue_we;
    logic [VW-1:0] queue_wd;
    logic          anc_we;
    logic [AW-1:0] anc_wa, anc_ra, anc_rb;
    logic [VW-1:0] anc_wd;

    assign link_m1 = link_reg - 1'b1;
    assign k_m1    = k_reg - 1'b1;
    assign clr_cmd = (cmd == tlca_pkg::CMD_CLR_ALL) || (cmd == tlca_pkg::CMD_CLR_REACH);

    always_comb
    begin
        head_we  = (cmd == tlca_pkg::CMD_CLR_ALL) || (cmd == tlca_pkg::CMD_ARC_WR);
        head_wa  = (cmd == tlca_pkg::CMD_CLR_ALL) ? cnt_reg : NW'(a_reg);
        head_wd  = (cmd == tlca_pkg::CMD_CLR_ALL) ? '0 : edge_cnt_reg + 1'b1;
        head_ra  = (cmd == tlca_pkg::CMD_TLOAD) ? NW'(queue_q) : NW'(a_reg);

        depth_we = (cmd == tlca_pkg::CMD_BINIT) || (cmd == tlca_pkg::CMD_ROOT)
                   || (cmd == tlca_pkg::CMD_JSET);
        case (cmd)
            tlca_pkg::CMD_BINIT:
            begin
                depth_wa = '0;
                depth_wd = '0;
            end
            tlca_pkg::CMD_ROOT:
            begin
                depth_wa = NW'(root_reg);
                depth_wd = DW'(1);
            end
            default:
            begin
                depth_wa = NW'(j_reg);
                depth_wd = dt_reg + 1'b1;
            end
        endcase
        case (cmd)
            tlca_pkg::CMD_TLOAD: depth_ra = NW'(queue_q);
            tlca_pkg::CMD_QRD2:  depth_ra = NW'(b_reg);
            tlca_pkg::CMD_LDRD:  depth_ra = NW'(anc_qa);
            default:             depth_ra = NW'(a_reg);
        endcase

        reach_we = clr_cmd || (cmd == tlca_pkg::CMD_ROOT) || (cmd == tlca_pkg::CMD_JSET);
        reach_wd = !clr_cmd;
        if (clr_cmd)
            reach_wa = cnt_reg;
        else if (cmd == tlca_pkg::CMD_ROOT)
            reach_wa = NW'(root_reg);
        else
            reach_wa = NW'(j_reg);
        case (cmd)
            tlca_pkg::CMD_JCHK: reach_ra = NW'(tgt_q);
            tlca_pkg::CMD_QRD2: reach_ra = NW'(b_reg);
            default:            reach_ra = NW'(a_reg);
        endcase

        queue_we = (cmd == tlca_pkg::CMD_ROOT) || (cmd == tlca_pkg::CMD_JSET);
        queue_wd = (cmd == tlca_pkg::CMD_ROOT) ? root_reg : j_reg;

        anc_we = (cmd == tlca_pkg::CMD_ZLEV) || (cmd == tlca_pkg::CMD_JSET)
                 || (cmd == tlca_pkg::CMD_PWR);
        case (cmd)
            tlca_pkg::CMD_ZLEV:
            begin
                anc_wa = {NW'(t_reg), k_reg};
                anc_wd = '0;
            end
            tlca_pkg::CMD_JSET:
            begin
                anc_wa = {NW'(j_reg), LW'(0)};
                anc_wd = t_reg;
            end
            default:
            begin
                anc_wa = {NW'(j_reg), k_reg};
                anc_wd = anc_qa;
            end
        endcase
        case (cmd)
            tlca_pkg::CMD_PRD: anc_ra = {NW'(p_reg), k_m1};
            tlca_pkg::CMD_RRD: anc_ra = {NW'(a_reg), LW'(0)};
            default:           anc_ra = {NW'(a_reg), k_reg};
        endcase
        anc_rb = {NW'(b_reg), k_reg};
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_q <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == tlca_pkg::CMD_ARC_WR)
        begin
            tgt_mem[edge_cnt_reg[EW-1:0]] <= b_reg;
            nxt_mem[edge_cnt_reg[EW-1:0]] <= head_q;
        end
        tgt_q <= tgt_mem[link_m1[EW-1:0]];
        nxt_q <= nxt_mem[link_m1[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
            depth_mem[depth_wa] <= depth_wd;
        depth_q <= depth_mem[depth_ra];
    end

    always_ff @(posedge clk)
    begin
        if (reach_we)
            reach_mem[reach_wa] <= reach_wd;
        reach_q <= reach_mem[reach_ra];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[tail_reg] <= queue_wd;
        queue_q <= queue_mem[head_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
            anc_mem[anc_wa] <= anc_wd;
        anc_qa <= anc_mem[anc_ra];
        anc_qb <= anc_mem[anc_rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            head_ptr_reg  <= '0;
            tail_reg      <= '0;
            edge_cnt_reg  <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            root_reg      <= tlca_pkg::ROOT_RESET;
        end
        else
        begin
            if (cfg_we)
                root_reg <= cfg_wdata;
            if (clr_cmd)
                cnt_reg <= status.clr_last ? '0 : cnt_reg + 1'b1;
            if (cmd == tlca_pkg::CMD_ARC_WR)
                edge_cnt_reg <= edge_cnt_reg + 1'b1;
            if (cmd == tlca_pkg::CMD_BINIT)
            begin
                head_ptr_reg <= '0;
                tail_reg     <= '0;
            end
            if (cmd == tlca_pkg::CMD_QRD)
                head_ptr_reg <= head_ptr_reg + 1'b1;
            if ((cmd == tlca_pkg::CMD_ROOT) || (cmd == tlca_pkg::CMD_JSET))
                tail_reg <= tail_reg + 1'b1;
            case (cmd)
                tlca_pkg::CMD_BINIT, tlca_pkg::CMD_ROOT: k_reg <= '0;
                tlca_pkg::CMD_ZLEV: k_reg <= status.k_last ? '0 : k_reg + 1'b1;
                tlca_pkg::CMD_JSET: k_reg <= LW'(1);
                tlca_pkg::CMD_PWR:  k_reg <= k_reg + 1'b1;
                tlca_pkg::CMD_QLAT: k_reg <= LW'(LEVELS - 1);
                tlca_pkg::CMD_LCHK, tlca_pkg::CMD_JCMP:
                    k_reg <= status.k_zero ? LW'(LEVELS - 1) : k_m1;
                default: k_reg <= k_reg;
            endcase
            if ((cmd == tlca_pkg::CMD_EMIT_FAIL) || (cmd == tlca_pkg::CMD_EMIT_MET)
                || (cmd == tlca_pkg::CMD_EMIT_ANC))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            tlca_pkg::CMD_LOAD:
            begin
                a_reg <= in_node_a;
                b_reg <= in_node_b;
            end
            tlca_pkg::CMD_ARC_WR:
            begin
                a_reg <= b_reg;
                b_reg <= a_reg;
            end
            tlca_pkg::CMD_BINIT: t_reg <= '0;
            tlca_pkg::CMD_ROOT:  t_reg <= root_reg;
            tlca_pkg::CMD_TLOAD: t_reg <= queue_q;
            tlca_pkg::CMD_LINK:
            begin
                link_reg <= head_q;
                dt_reg   <= depth_q;
            end
            tlca_pkg::CMD_JCHK:
            begin
                j_reg    <= tgt_q;
                link_reg <= nxt_q;
            end
            tlca_pkg::CMD_JSET: p_reg <= t_reg;
            tlca_pkg::CMD_PWR:  p_reg <= anc_qa;
            tlca_pkg::CMD_QRD2:
            begin
                ra_reg <= reach_q;
                da_reg <= depth_q;
            end
            tlca_pkg::CMD_QLAT:
            begin
                ok_reg <= ra_reg & reach_q;
                // keep the deeper node in a
                if (depth_q > da_reg)
                begin
                    a_reg  <= b_reg;
                    b_reg  <= a_reg;
                    db_reg <= da_reg;
                end
                else
                    db_reg <= depth_q;
            end
            tlca_pkg::CMD_LDRD: x_reg <= anc_qa;
            tlca_pkg::CMD_LCHK:
            begin
                if (depth_q >= db_reg)
                    a_reg <= x_reg;
            end
            tlca_pkg::CMD_JCMP:
            begin
                if (anc_qa != anc_qb)
                begin
                    a_reg <= anc_qa;
                    b_reg <= anc_qb;
                end
            end
            tlca_pkg::CMD_EMIT_FAIL:
            begin
                out_anc_reg   <= '0;
                out_found_reg <= 1'b0;
            end
            tlca_pkg::CMD_EMIT_MET:
            begin
                out_anc_reg   <= a_reg;
                out_found_reg <= 1'b1;
            end
            tlca_pkg::CMD_EMIT_ANC:
            begin
                out_anc_reg   <= anc_qa;
                out_found_reg <= 1'b1;
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

    always_comb
    begin
        status.clr_last   = (cnt_reg == NW'(MAX_NODES - 1));
        status.edge_ok    = (a_reg != '0) && (b_reg != '0) && (32'(a_reg) < MAX_NODES)
                            && (32'(b_reg) < MAX_NODES) && (32'(edge_cnt_reg) + 2 <= MAX_EDGES);
        status.q_range_ok = (a_reg != '0) && (b_reg != '0) && (32'(a_reg) < MAX_NODES)
                            && (32'(b_reg) < MAX_NODES);
        status.k_last     = (k_reg == LW'(LEVELS - 1));
        status.k_zero     = (k_reg == '0);
        status.root_ok    = (root_reg != '0) && (32'(root_reg) < MAX_NODES);
        status.q_empty    = (head_ptr_reg == tail_reg);
        status.link_zero  = (link_reg == '0);
        status.j_ok       = (j_reg != '0) && (32'(j_reg) < MAX_NODES) && !reach_q;
        status.pair_ok    = ok_reg;
        status.met        = (a_reg == b_reg);
        status.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_ancestor = out_anc_reg;
    assign out_found    = out_found_reg;

endmodule

FILE: src/tlca_ctrl.sv
module tlca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_opcode,
    input  tlca_pkg::status_t status,
    output logic              in_ready,
    output tlca_pkg::cmd_t    cmd
);

    tlca_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tlca_pkg::ST_CLRALL;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = tlca_pkg::CMD_NOP;
        in_ready   = 1'b0;
        case (state_reg)
            tlca_pkg::ST_CLRALL:
            begin
                cmd = tlca_pkg::CMD_CLR_ALL;
                if (status.clr_last)
                    state_next = tlca_pkg::ST_IDLE;
            end
            tlca_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = tlca_pkg::CMD_LOAD;
                    case (tlca_pkg::opcode_t'(in_opcode))
                        tlca_pkg::OP_ADD:   state_next = tlca_pkg::ST_ADD;
                        tlca_pkg::OP_BUILD: state_next = tlca_pkg::ST_BCLR;
                        tlca_pkg::OP_QUERY: state_next = tlca_pkg::ST_QCHK0;
                        default:            state_next = tlca_pkg::ST_IDLE;
                    endcase
                end
            end
            tlca_pkg::ST_ADD:
                state_next = status.edge_ok ? tlca_pkg::ST_ARC_RD : tlca_pkg::ST_IDLE;
            tlca_pkg::ST_ARC_RD:
            begin
                cmd        = tlca_pkg::CMD_ARC_RD;
                state_next = tlca_pkg::ST_ARC_WR;
            end
            tlca_pkg::ST_ARC_WR:
            begin
                cmd        = tlca_pkg::CMD_ARC_WR;
                state_next = tlca_pkg::ST_ARC_RD2;
            end
            tlca_pkg::ST_ARC_RD2:
            begin
                cmd        = tlca_pkg::CMD_ARC_RD;
                state_next = tlca_pkg::ST_ARC_WR2;
            end
            tlca_pkg::ST_ARC_WR2:
            begin
                cmd        = tlca_pkg::CMD_ARC_WR;
                state_next = tlca_pkg::ST_IDLE;
            end
            tlca_pkg::ST_BCLR:
            begin
                cmd = tlca_pkg::CMD_CLR_REACH;
                if (status.clr_last)
                    state_next = tlca_pkg::ST_BINIT;
            end
            tlca_pkg::ST_BINIT:
            begin
                cmd        = tlca_pkg::CMD_BINIT;
                state_next = tlca_pkg::ST_ZLEV0;
            end
            tlca_pkg::ST_ZLEV0:
            begin
                cmd = tlca_pkg::CMD_ZLEV;
                if (status.k_last)
                    state_next = status.root_ok ? tlca_pkg::ST_ROOT : tlca_pkg::ST_IDLE;
            end
            tlca_pkg::ST_ROOT:
            begin
                cmd        = tlca_pkg::CMD_ROOT;
                state_next = tlca_pkg::ST_ZLEVR;
            end
            tlca_pkg::ST_ZLEVR:
            begin
                cmd = tlca_pkg::CMD_ZLEV;
                if (status.k_last)
                    state_next = tlca_pkg::ST_QPOP;
            end
            tlca_pkg::ST_QPOP:
            begin
                if (status.q_empty)
                    state_next = tlca_pkg::ST_IDLE;
                else
                begin
                    cmd        = tlca_pkg::CMD_QRD;
                    state_next = tlca_pkg::ST_TLOAD;
                end
            end
            tlca_pkg::ST_TLOAD:
            begin
                cmd        = tlca_pkg::CMD_TLOAD;
                state_next = tlca_pkg::ST_LINK;
            end
            tlca_pkg::ST_LINK:
            begin
                cmd        = tlca_pkg::CMD_LINK;
                state_next = tlca_pkg::ST_EDGE;
            end
            tlca_pkg::ST_EDGE:
            begin
                if (status.link_zero)
                    state_next = tlca_pkg::ST_QPOP;
                else
                begin
                    cmd        = tlca_pkg::CMD_ERD;
                    state_next = tlca_pkg::ST_JCHK;
                end
            end
            tlca_pkg::ST_JCHK:
            begin
                cmd        = tlca_pkg::CMD_JCHK;
                state_next = tlca_pkg::ST_JTEST;
            end
            tlca_pkg::ST_JTEST:
            begin
                if (status.j_ok)
                begin
                    cmd        = tlca_pkg::CMD_JSET;
                    state_next = tlca_pkg::ST_PRD;
                end
                else
                    state_next = tlca_pkg::ST_EDGE;
            end
            tlca_pkg::ST_PRD:
            begin
                cmd        = tlca_pkg::CMD_PRD;
                state_next = tlca_pkg::ST_PWR;
            end
            tlca_pkg::ST_PWR:
            begin
                cmd        = tlca_pkg::CMD_PWR;
                state_next = status.k_last ? tlca_pkg::ST_EDGE : tlca_pkg::ST_PRD;
            end
            tlca_pkg::ST_QCHK0:
            begin
                if (status.q_range_ok)
                    state_next = tlca_pkg::ST_QRD1;
                else if (!status.out_busy)
                begin
                    cmd        = tlca_pkg::CMD_EMIT_FAIL;
                    state_next = tlca_pkg::ST_IDLE;
                end
            end
            tlca_pkg::ST_QRD1:
            begin
                cmd        = tlca_pkg::CMD_QRD1;
                state_next = tlca_pkg::ST_QRD2;
            end
            tlca_pkg::ST_QRD2:
            begin
                cmd        = tlca_pkg::CMD_QRD2;
                state_next = tlca_pkg::ST_QLAT;
            end
            tlca_pkg::ST_QLAT:
            begin
                cmd        = tlca_pkg::CMD_QLAT;
                state_next = tlca_pkg::ST_QOK;
            end
            tlca_pkg::ST_QOK:
            begin
                if (status.pair_ok)
                    state_next = tlca_pkg::ST_LRD;
                else if (!status.out_busy)
                begin
                    cmd        = tlca_pkg::CMD_EMIT_FAIL;
                    state_next = tlca_pkg::ST_IDLE;
                end
            end
            tlca_pkg::ST_LRD:
            begin
                cmd        = tlca_pkg::CMD_LRD;
                state_next = tlca_pkg::ST_LDRD;
            end
            tlca_pkg::ST_LDRD:
            begin
                cmd        = tlca_pkg::CMD_LDRD;
                state_next = tlca_pkg::ST_LCHK;
            end
            tlca_pkg::ST_LCHK:
            begin
                cmd        = tlca_pkg::CMD_LCHK;
                state_next = status.k_zero ? tlca_pkg::ST_MET : tlca_pkg::ST_LRD;
            end
            tlca_pkg::ST_MET:
            begin
                if (!status.met)
                    state_next = tlca_pkg::ST_JRD;
                else if (!status.out_busy)
                begin
                    cmd        = tlca_pkg::CMD_EMIT_MET;
                    state_next = tlca_pkg::ST_IDLE;
                end
            end
            tlca_pkg::ST_JRD:
            begin
                cmd        = tlca_pkg::CMD_JRD;
                state_next = tlca_pkg::ST_JCMP;
            end
            tlca_pkg::ST_JCMP:
            begin
                cmd        = tlca_pkg::CMD_JCMP;
                state_next = status.k_zero ? tlca_pkg::ST_RRD : tlca_pkg::ST_JRD;
            end
            tlca_pkg::ST_RRD:
            begin
                // the read is reissued each cycle while the output waits
                if (status.out_busy)
                    cmd = tlca_pkg::CMD_RRD;
                else
                begin
                    cmd        = tlca_pkg::CMD_RRD;
                    state_next = tlca_pkg::ST_EMIT;
                end
            end
            tlca_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = tlca_pkg::CMD_EMIT_ANC;
                    state_next = tlca_pkg::ST_IDLE;
                end
                else
                begin
                    cmd        = tlca_pkg::CMD_RRD;
                end
            end
            default:
                state_next = tlca_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: src/tree_lca_binary_lifting_core.sv
// add edge: a range check, then a head read and arc write per direction; build: reach clear
//   of all nodes, level setup, a queue pop per node, a reach check per arc, an ancestor row
//   per reached node; query: 3 memory steps per lift level, 2 per jump level
// one item at a time; a result waits in the output register while the next item is taken
// after reset a clearing pass over all nodes empties the adjacency heads and reach flags
//   before the first item is accepted; configuration writes are taken at any time
module tree_lca_binary_lifting_core #(
    parameter int MAX_NODES = tlca_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = tlca_pkg::MAX_EDGES_DEF,
    parameter int LEVELS    = tlca_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], node_a[11:2], node_b[21:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // ancestor[9:0]
    output logic [0:0]  m_tuser,   // found[0]
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);

    tlca_pkg::cmd_t    cmd;
    tlca_pkg::status_t status;
    logic [tlca_pkg::NODE_W-1:0] ancestor;
    logic found;

    tlca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tdata[1:0]),
        .status    (status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    tlca_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .LEVELS    (LEVELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_node_a    (s_tdata[11:2]),
        .in_node_b    (s_tdata[21:12]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_ancestor (ancestor),
        .out_found    (found)
    );

    assign m_tdata = {6'b0, ancestor};
    assign m_tuser = found;

    // a transaction with real work takes the controller out of idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tdata[1:0] != tlca_pkg::OP_NONE)) |=> !s_tready)
        else $error("controller still idle after accepting an item");

    // a found answer is always a real node
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[9:0] != 10'd0))
        else $error("found result with sentinel ancestor");

    // a miss carries a zero ancestor
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("not-found result with nonzero ancestor");

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES  = tlca_pkg::MAX_NODES_DEF;
    localparam int ARCS   = tlca_pkg::MAX_EDGES_DEF;
    localparam int LEVELS = tlca_pkg::LEVELS_DEF;

    typedef struct {
        logic [9:0] ancestor;
        logic       found;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;

    tree_lca_binary_lifting_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    int          root_sel;
    int          head_of[NODES];
    int          arc_to[ARCS];
    int          arc_next[ARCS];
    int          arc_total;
    int          node_lvl[NODES];
    bit          seen[NODES];
    int          jump[NODES][LEVELS];
    int          bfs_fifo[NODES];

    logic [23:0] pending_items[$];
    answer_t     answers_due[$];
    int          members[$];
    int          sent_cnt;
    int          taken_cnt;
    int          errors;
    int          cyc;
    bit          calm;

    function automatic void add_arc(int from, int to);
        arc_to[arc_total]   = to;
        arc_next[arc_total] = head_of[from];
        arc_total++;
        head_of[from] = arc_total;
    endfunction

    function automatic void walk_from_root();
        int hd;
        int tl;
        int t;
        int lnk;
        int j;
        hd = 0;
        tl = 0;
        foreach (seen[i])
            seen[i] = 0;
        node_lvl[0] = 0;
        for (int k = 0; k < LEVELS; k++)
            jump[0][k] = 0;
        if (root_sel == 0 || root_sel >= NODES)
            return;
        seen[root_sel]     = 1;
        node_lvl[root_sel] = 1;
        for (int k = 0; k < LEVELS; k++)
            jump[root_sel][k] = 0;
        bfs_fifo[tl++] = root_sel;
        while (hd < tl)
        begin
            t   = bfs_fifo[hd++];
            lnk = head_of[t];
            while (lnk != 0 && lnk <= ARCS)
            begin
                j   = arc_to[lnk-1];
                lnk = arc_next[lnk-1];
                if (j == 0 || j >= NODES || seen[j])
                    continue;
                seen[j]     = 1;
                node_lvl[j] = node_lvl[t] + 1;
                jump[j][0]  = t;
                for (int k = 1; k < LEVELS; k++)
                    jump[j][k] = jump[jump[j][k-1]][k-1];
                if (tl < NODES)
                    bfs_fifo[tl++] = j;
            end
        end
    endfunction

    function automatic int meet_point(int a, int b);
        int t;
        if (node_lvl[b] > node_lvl[a])
        begin
            t = a;
            a = b;
            b = t;
        end
        for (int k = LEVELS - 1; k >= 0; k--)
            if (node_lvl[jump[a][k]] >= node_lvl[b])
                a = jump[a][k];
        if (a == b)
            return a;
        for (int k = LEVELS - 1; k >= 0; k--)
            if (jump[a][k] != jump[b][k])
            begin
                a = jump[a][k];
                b = jump[b][k];
            end
        return jump[a][0];
    endfunction

    function automatic void apply_item(logic [23:0] d);
        tlca_pkg::opcode_t op;
        int      a;
        int      b;
        answer_t r;
        op = tlca_pkg::opcode_t'(d[1:0]);
        a  = d[11:2];
        b  = d[21:12];
        case (op)
            tlca_pkg::OP_ADD:
                if (a != 0 && b != 0 && a < NODES && b < NODES && arc_total + 2 <= ARCS)
                begin
                    add_arc(a, b);
                    add_arc(b, a);
                end
            tlca_pkg::OP_BUILD:
                walk_from_root();
            tlca_pkg::OP_QUERY:
            begin
                if (a == 0 || b == 0 || a >= NODES || b >= NODES || !seen[a] || !seen[b])
                begin
                    r.ancestor = '0;
                    r.found    = 1'b0;
                end
                else
                begin
                    r.ancestor = 10'(meet_point(a, b));
                    r.found    = 1'b1;
                end
                answers_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: new values at the falling edge
    always @(negedge clk)
    begin
        cyc++;
        calm = ((cyc / 3000) % 4 == 1);
        m_tready <= calm || ($urandom_range(99) >= 19);
        if (rst_n && sent_cnt == taken_cnt)
        begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 19))
            begin
                s_tdata  <= pending_items.pop_front();
                s_tvalid <= 1'b1;
                sent_cnt++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor and predictor at the rising edge
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (cfg_we)
                root_sel = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                taken_cnt++;
                apply_item(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("unexpected result transaction: ancestor %0d found %0d",
                           m_tdata[9:0], m_tuser[0]);
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (m_tdata[9:0] !== want.ancestor)
                    begin
                        $error("ancestor: expected %0d, got %0d", want.ancestor, m_tdata[9:0]);
                        errors++;
                    end
                    if (m_tuser[0] !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_item(tlca_pkg::opcode_t op, int a, int b);
        logic [9:0] na;
        logic [9:0] nb;
        na = 10'(a);
        nb = 10'(b);
        pending_items.push_back({2'b00, nb, na, op});
    endtask

    task automatic set_root(int value);
        wait (pending_items.size() == 0 && sent_cnt == taken_cnt && answers_due.size() == 0);
        repeat (64) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 10'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_chunk(int count);
        int  pick;
        int  a;
        int  b;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 64)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // grow the tree from a node already in it
                    a = members[$urandom_range(members.size() - 1)];
                    b = $urandom_range(1023, 1);
                    members.push_back(b);
                end
                else
                begin
                    a = $urandom_range(1023);
                    b = $urandom_range(1023);
                end
                push_item(tlca_pkg::OP_ADD, a, b);
            end
            else if (pick < 67)
                push_item(tlca_pkg::OP_BUILD, 0, 0);
            else if (pick < 98)
            begin
                if ($urandom_range(99) < 80)
                begin
                    a = members[$urandom_range(members.size() - 1)];
                    b = members[$urandom_range(members.size() - 1)];
                end
                else
                begin
                    a = $urandom_range(1023);
                    b = $urandom_range(1023);
                end
                push_item(tlca_pkg::OP_QUERY, a, b);
            end
            else
                push_item(tlca_pkg::OP_NONE, $urandom_range(1023), $urandom_range(1023));
        end
        push_item(tlca_pkg::OP_QUERY, members[$urandom_range(members.size() - 1)],
                  members[$urandom_range(members.size() - 1)]);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        sent_cnt  = 0;
        taken_cnt = 0;
        errors    = 0;
        cyc       = 0;
        root_sel  = tlca_pkg::ROOT_RESET;
        arc_total = 0;
        foreach (head_of[i])
        begin
            head_of[i]  = 0;
            node_lvl[i] = 0;
            seen[i]     = 0;
            for (int k = 0; k < LEVELS; k++)
                jump[i][k] = 0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // query before any build: nothing reached
        push_item(tlca_pkg::OP_QUERY, 1, 1);
        push_item(tlca_pkg::OP_ADD, 1, 2);
        push_item(tlca_pkg::OP_ADD, 2, 3);
        push_item(tlca_pkg::OP_ADD, 1, 4);
        push_item(tlca_pkg::OP_ADD, 1023, 1);
        push_item(tlca_pkg::OP_ADD, 0, 5);
        push_item(tlca_pkg::OP_ADD, 5, 0);
        push_item(tlca_pkg::OP_NONE, 1023, 1023);
        push_item(tlca_pkg::OP_BUILD, 0, 0);
        push_item(tlca_pkg::OP_QUERY, 3, 4);
        push_item(tlca_pkg::OP_QUERY, 2, 3);
        push_item(tlca_pkg::OP_QUERY, 3, 3);
        push_item(tlca_pkg::OP_QUERY, 1023, 3);
        push_item(tlca_pkg::OP_QUERY, 0, 2);
        push_item(tlca_pkg::OP_QUERY, 5, 1);
        push_item(tlca_pkg::OP_QUERY, 1023, 1023);
        // cycle through the back edge 3-4
        push_item(tlca_pkg::OP_ADD, 3, 4);
        push_item(tlca_pkg::OP_BUILD, 0, 0);
        push_item(tlca_pkg::OP_QUERY, 4, 3);

        set_root(1023);
        push_item(tlca_pkg::OP_BUILD, 0, 0);
        push_item(tlca_pkg::OP_QUERY, 3, 4);
        push_item(tlca_pkg::OP_QUERY, 2, 1023);
        push_item(tlca_pkg::OP_QUERY, 1, 1023);

        // invalid root: build reaches nothing
        set_root(0);
        push_item(tlca_pkg::OP_BUILD, 0, 0);
        push_item(tlca_pkg::OP_QUERY, 1, 2);

        members = '{1, 2, 3, 4, 1023};
        for (int c = 0; c < 4; c++)
        begin
            set_root(c == 0 ? 1 : members[$urandom_range(members.size() - 1)]);
            random_chunk(410);
        end

        wait (pending_items.size() == 0 && sent_cnt == taken_cnt && answers_due.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tree_lca_binary_lifting_core: match");
        else
            $display("tree_lca_binary_lifting_core: mismatch");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tree_lca_binary_lifting_core: mismatch");
        $finish;
    end
endmodule
